FILE: sv/pcsm_pkg.sv
// Shared types and constants of the P-code stack machine.
package pcsm_pkg;

    localparam logic [4:0] OP_LDA   = 5'd0;
    localparam logic [4:0] OP_LDV   = 5'd1;
    localparam logic [4:0] OP_LDC   = 5'd2;
    localparam logic [4:0] OP_JMP   = 5'd3;
    localparam logic [4:0] OP_JIF   = 5'd4;
    localparam logic [4:0] OP_JSR   = 5'd5;
    localparam logic [4:0] OP_RSR   = 5'd6;
    localparam logic [4:0] OP_RD    = 5'd7;
    localparam logic [4:0] OP_RDLN  = 5'd8;
    localparam logic [4:0] OP_WRT   = 5'd9;
    localparam logic [4:0] OP_WRTLN = 5'd10;
    localparam logic [4:0] OP_AFF   = 5'd11;
    localparam logic [4:0] OP_STOP  = 5'd12;
    localparam logic [4:0] OP_SUP   = 5'd13;
    localparam logic [4:0] OP_SUPE  = 5'd14;
    localparam logic [4:0] OP_INF   = 5'd15;
    localparam logic [4:0] OP_INFE  = 5'd16;
    localparam logic [4:0] OP_EG    = 5'd17;
    localparam logic [4:0] OP_DIFF  = 5'd18;
    localparam logic [4:0] OP_ADD   = 5'd19;
    localparam logic [4:0] OP_SUB   = 5'd20;
    localparam logic [4:0] OP_DIV   = 5'd21;
    localparam logic [4:0] OP_MULT  = 5'd22;
    localparam logic [4:0] OP_NEG   = 5'd23;
    localparam logic [4:0] OP_INC   = 5'd24;
    localparam logic [4:0] OP_DEC   = 5'd25;
    localparam logic [4:0] OP_AND   = 5'd26;
    localparam logic [4:0] OP_OR    = 5'd27;
    localparam logic [4:0] OP_NOT   = 5'd28;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW = 3'd1;
    localparam logic [2:0] ERR_ADDRESS  = 3'd2;
    localparam logic [2:0] ERR_DIVZERO  = 3'd3;
    localparam logic [2:0] ERR_UNSUPP   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } pcsm_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

FILE: sv/pcode_stack_machine_top.sv
// P-code stack machine: one instruction per input item, stack kept in a RAM.
//
// Input channel (in_valid/in_ready) carries op, operand and read_value; the
// output channel (out_valid/out_ready) returns one item per instruction with
// next_pc, the printed value, halt and error status. cfg_write_en loads the
// stack pointer from cfg_write_data (clamped) and may be used while idle.
//
// Each item passes through RDA, RDB, EXEC and WB before the next one is
// accepted: two sequenced reads of the stack RAM (top, second operand),
// execute and write-back. DIV with a nonzero divisor also waits in ST_DIV
// for the bit-serial divider. The result sits in an output register; the
// next item is accepted while it waits, and write-back holds if that
// register is still full when the following result is ready.
//
// After reset a clearing pass zeroes the stack RAM, one entry per cycle,
// with in_ready low. The pc and halt flag reset to zero and the stack
// pointer to -1.
module pcode_stack_machine_top #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic signed [10:0] cfg_write_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         op,
    input  logic signed [31:0] operand,
    input  logic signed [31:0] read_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        next_pc,
    output logic               write_valid,
    output logic signed [31:0] write_value,
    output logic               write_newline,
    output logic               halted,
    output logic [2:0]         error_code
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = AW + 1;
    localparam logic signed [SPW-1:0] SP_ONE   = SPW'(1);
    localparam logic signed [SPW-1:0] SP_TWO   = SPW'(2);
    localparam logic signed [SPW-1:0] SP_THREE = SPW'(3);
    localparam logic signed [SPW-1:0] SP_ZERO  = SPW'(0);
    localparam logic signed [SPW-1:0] SP_EMPTY = SPW'(-1);
    localparam logic signed [SPW-1:0] SP_FULL  = SPW'(STACK_DEPTH - 1);

    pcsm_pkg::pcsm_state_t state_reg, state_next;

    logic [15:0]           pc_reg;
    logic signed [SPW-1:0] sp_reg;
    logic                  halt_reg;
    logic [AW:0]           clr_cnt_reg;

    logic [4:0]  op_reg;
    logic [31:0] operand_reg;
    logic [31:0] rdval_reg;
    logic [31:0] top_reg;
    logic [31:0] sec_reg;
    logic [31:0] mul_reg;
    logic        div_neg_reg;

    logic        out_valid_reg;
    logic [15:0] out_pc_reg;
    logic        out_wv_reg;
    logic [31:0] out_wval_reg;
    logic        out_wnl_reg;
    logic        out_halt_reg;
    logic [2:0]  out_err_reg;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    pcsm_pkg::div_req_t div_req;
    pcsm_pkg::div_rsp_t div_rsp;

    // write-back results
    logic [15:0]           wb_pc;
    logic signed [SPW-1:0] wb_sp;
    logic                  wb_halt;
    logic [2:0]            wb_err;
    logic                  wb_wv;
    logic [31:0]           wb_wval;
    logic                  wb_wnl;
    logic                  wb_we;
    logic [AW-1:0]         wb_waddr;
    logic [31:0]           wb_wdata;
    logic                  wb_go;
    logic                  in_fire;
    logic                  clear_done;
    logic                  div_start;

    logic signed [SPW-1:0] sp_m1, sp_m2, sp_m3, sp_p1;
    logic                  sp_neg, sp_lt1, sp_lt3, sp_full;
    logic signed [31:0]    cfg_ext;
    logic signed [SPW-1:0] cfg_sp;
    logic                  rel_r;
    logic [31:0]           quot;

    assign sp_m1   = sp_reg - SP_ONE;
    assign sp_m2   = sp_reg - SP_TWO;
    assign sp_m3   = sp_reg - SP_THREE;
    assign sp_p1   = sp_reg + SP_ONE;
    assign sp_neg  = sp_reg < SP_ZERO;
    assign sp_lt1  = sp_reg < SP_ONE;
    assign sp_lt3  = sp_reg < SP_THREE;
    assign sp_full = sp_reg == SP_FULL;

    assign cfg_ext = {{21{cfg_write_data[10]}}, cfg_write_data};

    always_comb
    begin
        if (cfg_ext < -32'sd1)
        begin
            cfg_sp = SP_EMPTY;
        end
        else if (cfg_ext > 32'(STACK_DEPTH - 1))
        begin
            cfg_sp = SP_FULL;
        end
        else
        begin
            cfg_sp = cfg_ext[SPW-1:0];
        end
    end

    assign clear_done = clr_cnt_reg == (AW+1)'(STACK_DEPTH - 1);
    assign in_ready   = state_reg == pcsm_pkg::ST_IDLE;
    assign in_fire    = in_valid && in_ready;
    assign wb_go      = (state_reg == pcsm_pkg::ST_WB) && (!out_valid_reg || out_ready);
    assign div_start  = (state_reg == pcsm_pkg::ST_EXEC) && !halt_reg
                        && (op_reg == pcsm_pkg::OP_DIV) && !sp_lt1 && (top_reg != 32'd0);

    pcsm_ram #(
        .WIDTH (32),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign div_req.start    = div_start;
    assign div_req.dividend = ram_rdata[31] ? (32'd0 - ram_rdata) : ram_rdata;
    assign div_req.divisor  = top_reg[31] ? (32'd0 - top_reg) : top_reg;

    pcsm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign quot = div_neg_reg ? (32'd0 - div_rsp.quotient) : div_rsp.quotient;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcsm_pkg::ST_CLEAR: if (clear_done) state_next = pcsm_pkg::ST_IDLE;
            pcsm_pkg::ST_IDLE:  if (in_fire) state_next = pcsm_pkg::ST_RDA;
            pcsm_pkg::ST_RDA:   state_next = pcsm_pkg::ST_RDB;
            pcsm_pkg::ST_RDB:   state_next = pcsm_pkg::ST_EXEC;
            pcsm_pkg::ST_EXEC:  state_next = div_start ? pcsm_pkg::ST_DIV : pcsm_pkg::ST_WB;
            pcsm_pkg::ST_DIV:   if (div_rsp.done) state_next = pcsm_pkg::ST_WB;
            pcsm_pkg::ST_WB:    if (wb_go) state_next = pcsm_pkg::ST_IDLE;
            default:            state_next = pcsm_pkg::ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb
    begin
        ram_raddr = sp_reg[AW-1:0];
        unique case (state_reg)
            pcsm_pkg::ST_RDA:
            begin
                ram_raddr = (op_reg == pcsm_pkg::OP_LDV) ? operand_reg[AW-1:0]
                                                         : sp_reg[AW-1:0];
            end
            pcsm_pkg::ST_RDB:
            begin
                ram_raddr = (op_reg == pcsm_pkg::OP_AND || op_reg == pcsm_pkg::OP_OR)
                            ? sp_m3[AW-1:0] : sp_m1[AW-1:0];
            end
            default: ram_raddr = sp_reg[AW-1:0];
        endcase
        if (state_reg == pcsm_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg[AW-1:0];
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = wb_we && wb_go;
            ram_waddr = wb_waddr;
            ram_wdata = wb_wdata;
        end
    end

    // relational result, a = second, b = top
    always_comb
    begin
        case (op_reg)
            pcsm_pkg::OP_SUP:  rel_r = $signed(top_reg) < $signed(sec_reg);
            pcsm_pkg::OP_SUPE: rel_r = !($signed(sec_reg) < $signed(top_reg));
            pcsm_pkg::OP_INF:  rel_r = $signed(sec_reg) < $signed(top_reg);
            pcsm_pkg::OP_INFE: rel_r = !($signed(top_reg) < $signed(sec_reg));
            pcsm_pkg::OP_EG:   rel_r = sec_reg == top_reg;
            default:           rel_r = sec_reg != top_reg;
        endcase
    end

    // instruction execute and write-back
    always_comb
    begin
        wb_pc    = pc_reg + 16'd1;
        wb_sp    = sp_reg;
        wb_halt  = halt_reg;
        wb_err   = pcsm_pkg::ERR_NONE;
        wb_wv    = 1'b0;
        wb_wval  = '0;
        wb_wnl   = 1'b0;
        wb_we    = 1'b0;
        wb_waddr = sp_p1[AW-1:0];
        wb_wdata = '0;
        if (halt_reg)
        begin
            wb_pc = pc_reg;
        end
        else
        begin
            unique case (op_reg) inside
                pcsm_pkg::OP_LDA, pcsm_pkg::OP_LDC, pcsm_pkg::OP_LDV:
                begin
                    wb_pc = pc_reg + 16'd2;
                    if (op_reg == pcsm_pkg::OP_LDV && operand_reg >= 32'(STACK_DEPTH))
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else if (sp_full)
                    begin
                        wb_err = pcsm_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        wb_sp    = sp_p1;
                        wb_we    = 1'b1;
                        wb_wdata = (op_reg == pcsm_pkg::OP_LDV) ? top_reg : operand_reg;
                    end
                end
                pcsm_pkg::OP_JMP:
                begin
                    wb_pc = operand_reg[15:0];
                end
                pcsm_pkg::OP_JIF:
                begin
                    if (sp_neg)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                        wb_pc  = pc_reg + 16'd2;
                    end
                    else if (top_reg == 32'd0)
                    begin
                        wb_pc = operand_reg[15:0];
                    end
                    else
                    begin
                        wb_pc = pc_reg + 16'd2;
                    end
                end
                pcsm_pkg::OP_RD, pcsm_pkg::OP_RDLN:
                begin
                    if (sp_full)
                    begin
                        wb_err = pcsm_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        wb_sp    = sp_p1;
                        wb_we    = 1'b1;
                        wb_wdata = rdval_reg;
                    end
                end
                pcsm_pkg::OP_WRT, pcsm_pkg::OP_WRTLN:
                begin
                    if (sp_neg)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else
                    begin
                        wb_wv   = 1'b1;
                        wb_wval = top_reg;
                        wb_wnl  = op_reg == pcsm_pkg::OP_WRTLN;
                        wb_sp   = sp_m1;
                    end
                end
                pcsm_pkg::OP_AFF:
                begin
                    if (sp_lt1 || sec_reg >= 32'(STACK_DEPTH))
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else
                    begin
                        wb_we    = 1'b1;
                        wb_waddr = sec_reg[AW-1:0];
                        wb_wdata = top_reg;
                        wb_sp    = sp_m2;
                    end
                end
                pcsm_pkg::OP_STOP:
                begin
                    wb_pc   = pc_reg;
                    wb_halt = 1'b1;
                end
                [pcsm_pkg::OP_SUP:pcsm_pkg::OP_DIFF]:
                begin
                    if (sp_lt1)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else if (sp_full)
                    begin
                        wb_err = pcsm_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        wb_sp    = sp_p1;
                        wb_we    = 1'b1;
                        wb_wdata = {31'd0, rel_r};
                    end
                end
                [pcsm_pkg::OP_ADD:pcsm_pkg::OP_MULT]:
                begin
                    if (sp_lt1)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else
                    begin
                        wb_sp    = sp_m1;
                        wb_we    = 1'b1;
                        wb_waddr = sp_m1[AW-1:0];
                        case (op_reg)
                            pcsm_pkg::OP_ADD:  wb_wdata = sec_reg + top_reg;
                            pcsm_pkg::OP_SUB:  wb_wdata = sec_reg - top_reg;
                            pcsm_pkg::OP_MULT: wb_wdata = mul_reg;
                            default:
                            begin
                                if (top_reg == 32'd0)
                                begin
                                    wb_wdata = '0;
                                    wb_err   = pcsm_pkg::ERR_DIVZERO;
                                end
                                else
                                begin
                                    wb_wdata = quot;
                                end
                            end
                        endcase
                    end
                end
                [pcsm_pkg::OP_NEG:pcsm_pkg::OP_DEC]:
                begin
                    if (sp_neg)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else
                    begin
                        wb_we    = 1'b1;
                        wb_waddr = sp_reg[AW-1:0];
                        case (op_reg)
                            pcsm_pkg::OP_NEG: wb_wdata = 32'd0 - top_reg;
                            pcsm_pkg::OP_INC: wb_wdata = top_reg + 32'd1;
                            default:          wb_wdata = top_reg - 32'd1;
                        endcase
                    end
                end
                pcsm_pkg::OP_AND, pcsm_pkg::OP_OR, pcsm_pkg::OP_NOT:
                begin
                    if ((op_reg == pcsm_pkg::OP_NOT) ? sp_neg : sp_lt3)
                    begin
                        wb_err = pcsm_pkg::ERR_ADDRESS;
                    end
                    else if (sp_full)
                    begin
                        wb_err = pcsm_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        wb_sp = sp_p1;
                        wb_we = 1'b1;
                        case (op_reg)
                            pcsm_pkg::OP_NOT:
                                wb_wdata = {31'd0, top_reg == 32'd0};
                            pcsm_pkg::OP_AND:
                                wb_wdata = {31'd0, sec_reg == 32'd1 && top_reg == 32'd1};
                            default:
                                wb_wdata = {31'd0, sec_reg == 32'd1 || top_reg == 32'd1};
                        endcase
                    end
                end
                default:
                begin
                    wb_err = pcsm_pkg::ERR_UNSUPP;
                    wb_pc  = pc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcsm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            pc_reg        <= '0;
            sp_reg        <= SP_EMPTY;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pcsm_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
            end
            // hold the result until taken, refill on write-back
            out_valid_reg <= wb_go || (out_valid_reg && !out_ready);
            if (wb_go)
            begin
                pc_reg   <= wb_pc;
                sp_reg   <= wb_sp;
                halt_reg <= wb_halt;
            end
            else if (cfg_write_en)
            begin
                sp_reg <= cfg_sp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg      <= op;
            operand_reg <= operand;
            rdval_reg   <= read_value;
        end
        if (state_reg == pcsm_pkg::ST_RDB)
        begin
            top_reg <= ram_rdata;
        end
        if (state_reg == pcsm_pkg::ST_EXEC)
        begin
            sec_reg     <= ram_rdata;
            mul_reg     <= ram_rdata * top_reg;
            div_neg_reg <= ram_rdata[31] ^ top_reg[31];
        end
        if (wb_go)
        begin
            out_pc_reg   <= wb_pc;
            out_wv_reg   <= wb_wv;
            out_wval_reg <= wb_wval;
            out_wnl_reg  <= wb_wnl;
            out_halt_reg <= wb_halt;
            out_err_reg  <= wb_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = out_pc_reg;
    assign write_valid   = out_wv_reg;
    assign write_value   = out_wval_reg;
    assign write_newline = out_wnl_reg;
    assign halted        = out_halt_reg;
    assign error_code    = out_err_reg;

endmodule

FILE: sv/pcsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pcsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/pcsm_divider.sv
// Iterative unsigned 32-bit restoring divider, one quotient bit per cycle.
module pcsm_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  pcsm_pkg::div_req_t req,
    output pcsm_pkg::div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] q_reg;
    logic [31:0] r_reg;
    logic [31:0] d_reg;
    logic [32:0] trial;

    assign trial = {r_reg, q_reg[31]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= req.dividend;
            r_reg <= '0;
            d_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

FILE: sv/pcsm_checker.sv
// Port-level checks of the P-code stack machine and their bind.
module pcsm_port_checks (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [15:0]        next_pc,
    input logic               write_valid,
    input logic signed [31:0] write_value,
    input logic               write_newline,
    input logic               halted,
    input logic [2:0]         error_code
);

    // a stalled result item stays valid with next_pc and error_code unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc) && $stable(error_code))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> write_value == 32'd0 && !write_newline)
        else $error("write fields set without write_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code != pcsm_pkg::ERR_NONE |-> !write_valid)
        else $error("value printed by a failing item");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> error_code == pcsm_pkg::ERR_NONE)
        else $error("error reported while halted");

endmodule

bind pcode_stack_machine_top pcsm_port_checks u_pcsm_port_checks (.*);
